// File: sv/ffra_pkg.sv
`timescale 1ns / 1ps

package ffra_pkg;

	// field widths fixed by the word layout
	localparam int REG_W    = 7;
	localparam int LR_W     = 12;
	localparam int VAL_ID_W = 10;
	localparam int CNT_W    = 9;
	localparam int RUN_W    = 3;
	localparam int SRC_N_W  = 2;
	localparam int STAT_W   = 2;
	// value ids plus a run length and value counts compare at this width
	localparam int SUM_W    = 11;
	// busy bits examined per search cycle
	localparam int CHUNK    = 16;

	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_LOWER = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd2;

	typedef struct packed {
		logic                opcode;
		logic [LR_W-1:0]     instr_index;
		logic [SRC_N_W-1:0]  source_count;
		logic [VAL_ID_W-1:0] source_a;
		logic [VAL_ID_W-1:0] source_b;
		logic [VAL_ID_W-1:0] dest_value;
		logic [RUN_W-1:0]    define_count;
	} ffra_in_t;

	typedef struct packed {
		logic [REG_W-1:0]  source_a_reg;
		logic [REG_W-1:0]  source_b_reg;
		logic [REG_W-1:0]  dest_reg;
		logic [STAT_W-1:0] status;
		logic [REG_W-1:0]  high_water;
	} ffra_out_t;

	// run finder result, pos is the offset from the first register
	typedef struct packed {
		logic             done;
		logic             found;
		logic [REG_W-1:0] pos;
	} ffra_fit_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_READ,
		ST_FIT,
		ST_SEARCH,
		ST_COMMIT,
		ST_WRITE,
		ST_DONE
	} ffra_state_t;

endpackage

// File: sv/first_fit_register_allocator.sv
`timescale 1ns / 1ps
// channel | direction | handshake                | word
// req     | in        | req_valid / req_ready    | req_word   (ffra_in_t)
// rsp     | out       | rsp_valid / rsp_ready    | rsp_word   (ffra_out_t)
// cfg     | in        | cfg_we, no wait          | cfg_data   (value count)
//
// scan word: IDLE, SCAN_A, SCAN_B, DONE (up to two last-reader writes)
// lower word: READ over both source slots and the run, FIT, SEARCH, COMMIT, then
//   one map write per run value when the run is placed, and DONE; the search
//   walks the busy bits 16 per cycle
// everything runs off one read and one write port per map memory
// after reset both maps are swept to zero, with req_ready low
// the response register lets the next word enter while a result waits

module first_fit_register_allocator #(
	parameter int MAX_VALUES = 256,
	parameter int FIRST_REG  = 16,
	parameter int LAST_REG   = 95
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  ffra_pkg::ffra_in_t         req_word,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output ffra_pkg::ffra_out_t        rsp_word,
	input  logic                       cfg_we,
	input  logic [ffra_pkg::CNT_W-1:0] cfg_data
);
	import ffra_pkg::*;

	localparam int SPAN   = LAST_REG - FIRST_REG + 1;
	localparam int VAL_W  = $clog2(MAX_VALUES);
	localparam int MAXRUN = (1 << RUN_W) - 1;
	localparam int SLOT_W = $clog2(MAXRUN + 3);

	localparam logic [SUM_W-1:0]  MAXV     = SUM_W'(MAX_VALUES);
	localparam logic [REG_W-1:0]  FIRST_R  = REG_W'(FIRST_REG);
	localparam logic [REG_W:0]    FIRST_X  = (REG_W+1)'(FIRST_REG);
	localparam logic [REG_W:0]    TOP_X    = (REG_W+1)'(LAST_REG + 1);
	// read slots: two sources, then the destination run
	localparam logic [SLOT_W-1:0] SLOT_A    = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_B    = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_DEST = SLOT_W'(2);

	// register of each value (0 = none) and last reading instruction
	logic [REG_W-1:0] map_mem [MAX_VALUES];
	logic [LR_W-1:0]  lr_mem  [MAX_VALUES];

	ffra_state_t state_q, state_d;

	logic [CNT_W-1:0]  vcount_q;
	ffra_in_t          item_q;
	logic [VAL_W-1:0]  clr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [RUN_W-1:0]  wr_k_q;

	logic              rd_en_s1;
	logic [SLOT_W-1:0] rd_slot_s1;
	logic [REG_W-1:0]  rd_map_s1;
	logic [LR_W-1:0]   rd_lr_s1;

	logic [REG_W-1:0]  sreg_a_q, sreg_b_q;
	logic              bad_src_q, redef_q, bad_def_q, full_q, ok_q;
	logic [MAXRUN-1:0] dead_q;
	logic [SPAN-1:0]   free_q;
	logic [SPAN-1:0]   busy_q;
	logic [REG_W:0]    high_q;
	logic              found_q;
	logic [REG_W-1:0]  pos_q;
	ffra_out_t         rsp_q;
	logic              rsp_valid_q;

	// datapath terms
	logic [SUM_W-1:0]  vc, a_x, b_x, dest_x, rd_val, wr_val;
	logic [RUN_W-1:0]  run, rd_k, rd_k_s1;
	logic              use_a, use_b, a_in, b_in, has_run, range_bad, rd_ok;
	logic              last_slot, alloc_ok, take_word, load_rsp;
	logic [SPAN-1:0]   alloc_mask;
	logic [REG_W:0]    run_top;
	logic [REG_W-1:0]  wr_reg;
	ffra_out_t         rsp_d;
	ffra_fit_t         fit_res;

	// memory and control strobes
	logic              rd_en, map_we, lr_we, find_start;
	logic [VAL_W-1:0]  rd_addr, map_wa, lr_wa;
	logic [REG_W-1:0]  map_wd;
	logic [LR_W-1:0]   lr_wd;

	function automatic logic [SPAN-1:0] reg_onehot(input logic [REG_W-1:0] r);
		logic [SPAN-1:0] m;
		m = '0;
		for (int p = 0; p < SPAN; p++) begin
			if ({1'b0, r} == FIRST_X + (REG_W+1)'(p)) begin
				m[p] = 1'b1;
			end
		end
		return m;
	endfunction

	always_comb begin
		vc = (SUM_W'(vcount_q) < MAXV) ? SUM_W'(vcount_q) : MAXV;
		a_x = SUM_W'(item_q.source_a);
		b_x = SUM_W'(item_q.source_b);
		dest_x = SUM_W'(item_q.dest_value);
		run = item_q.define_count;
		// a source count of three behaves as two
		use_a = (item_q.source_count != '0);
		use_b = item_q.source_count[1];
		a_in = (a_x < vc);
		b_in = (b_x < vc);
		has_run = (run != '0);
		range_bad = (dest_x + SUM_W'(run)) > vc;

		rd_k = RUN_W'(slot_q - SLOT_DEST);
		rd_k_s1 = RUN_W'(rd_slot_s1 - SLOT_DEST);
		if (slot_q == SLOT_A) begin
			rd_val = a_x;
			rd_ok = use_a;
		end else if (slot_q == SLOT_B) begin
			rd_val = b_x;
			rd_ok = use_b;
		end else begin
			rd_val = dest_x + SUM_W'(rd_k);
			rd_ok = 1'b1;
		end
		last_slot = (slot_q == SLOT_W'(run) + SLOT_DEST - SLOT_W'(1));

		wr_val = dest_x + SUM_W'(wr_k_q);
		wr_reg = FIRST_R + pos_q + REG_W'(wr_k_q);

		alloc_ok = has_run && !range_bad && !redef_q && found_q;
		run_top = FIRST_X + {1'b0, pos_q} + (REG_W+1)'(run);

		// new run, minus the values that nobody reads later
		for (int p = 0; p < SPAN; p++) begin
			logic [REG_W:0] off;
			off = (REG_W+1)'(p) - {1'b0, pos_q};
			alloc_mask[p] = alloc_ok && (off < (REG_W+1)'(run))
				&& !dead_q[off[RUN_W-1:0]];
		end

		take_word = (state_q == ST_IDLE) && req_valid;
		load_rsp = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

		rsp_d.source_a_reg = sreg_a_q;
		rsp_d.source_b_reg = sreg_b_q;
		rsp_d.dest_reg = ok_q ? (FIRST_R + pos_q) : FIRST_R;
		if (full_q) begin
			rsp_d.status = STAT_NO_ROOM;
		end else if (bad_src_q || bad_def_q) begin
			rsp_d.status = STAT_INVALID;
		end else begin
			rsp_d.status = STAT_OK;
		end
		rsp_d.high_water = high_q[REG_W-1:0];
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == VAL_W'(MAX_VALUES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req_word.opcode == OP_LOWER) ? ST_READ : ST_SCAN_A;
				end
			end
			ST_SCAN_A: state_d = ST_SCAN_B;
			ST_SCAN_B: state_d = ST_DONE;
			ST_READ: begin
				if (last_slot) begin
					state_d = ST_FIT;
				end
			end
			ST_FIT: state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (fit_res.done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: state_d = alloc_ok ? ST_WRITE : ST_DONE;
			ST_WRITE: begin
				if (wr_k_q == run - RUN_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// sequencer outputs: memory ports and search start
	always_comb begin
		req_ready = 1'b0;
		rd_en = 1'b0;
		rd_addr = VAL_W'(rd_val);
		map_we = 1'b0;
		map_wa = VAL_W'(wr_val);
		map_wd = wr_reg;
		lr_we = 1'b0;
		lr_wa = VAL_W'(a_x);
		lr_wd = item_q.instr_index;
		find_start = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = '0;
				lr_we = 1'b1;
				lr_wa = clr_q;
				lr_wd = '0;
			end
			ST_IDLE: req_ready = 1'b1;
			ST_SCAN_A: lr_we = use_a && a_in;
			ST_SCAN_B: begin
				lr_we = use_b && b_in;
				lr_wa = VAL_W'(b_x);
			end
			ST_READ: rd_en = rd_ok && (rd_val < vc);
			ST_FIT: find_start = 1'b1;
			ST_WRITE: map_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (lr_we) begin
			lr_mem[lr_wa] <= lr_wd;
		end
		if (rd_en) begin
			rd_map_s1 <= map_mem[rd_addr];
			rd_lr_s1 <= lr_mem[rd_addr];
		end
	end

	ffra_run_finder #(
		.SPAN(SPAN)
	) u_finder (
		.clk(clk),
		.arst_n(arst_n),
		.start(find_start),
		.busy(busy_q),
		.run_len(item_q.define_count),
		.fit(fit_res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			vcount_q <= '0;
			clr_q <= '0;
			slot_q <= '0;
			wr_k_q <= '0;
			rd_en_s1 <= 1'b0;
			busy_q <= '0;
			high_q <= FIRST_X;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_en_s1 <= rd_en;
			if (cfg_we) begin
				vcount_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + VAL_W'(1);
			end
			if (take_word) begin
				slot_q <= '0;
			end else if (state_q == ST_READ) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (state_q == ST_COMMIT) begin
				wr_k_q <= '0;
				// allocation first, then every free of this word
				busy_q <= (busy_q | alloc_mask) & ~free_q;
				if (alloc_ok && run_top > high_q) begin
					high_q <= run_top;
				end
			end else if (state_q == ST_WRITE) begin
				wr_k_q <= wr_k_q + RUN_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// word payload and per-word gathered flags
	always_ff @(posedge clk) begin
		rd_slot_s1 <= slot_q;
		if (take_word) begin
			item_q <= req_word;
			sreg_a_q <= FIRST_R;
			sreg_b_q <= FIRST_R;
			bad_src_q <= 1'b0;
			redef_q <= 1'b0;
			bad_def_q <= 1'b0;
			full_q <= 1'b0;
			ok_q <= 1'b0;
			dead_q <= '0;
			free_q <= '0;
		end else begin
			// a used source beyond the value count, or one with no register
			if ((state_q == ST_READ && slot_q < SLOT_DEST && rd_ok && !(rd_val < vc))
				|| (rd_en_s1 && rd_slot_s1 < SLOT_DEST && rd_map_s1 == '0)) begin
				bad_src_q <= 1'b1;
			end
			if (rd_en_s1) begin
				if (rd_slot_s1 < SLOT_DEST) begin
					if (rd_map_s1 != '0 && rd_slot_s1 == SLOT_A) begin
						sreg_a_q <= rd_map_s1;
					end else if (rd_map_s1 != '0) begin
						sreg_b_q <= rd_map_s1;
					end
					if (rd_lr_s1 == item_q.instr_index && rd_map_s1 != '0) begin
						free_q <= free_q | reg_onehot(rd_map_s1);
					end
				end else begin
					if (rd_map_s1 != '0) begin
						redef_q <= 1'b1;
					end
					// no later reader: free the old register, or drop the new one
					if (rd_lr_s1 <= item_q.instr_index) begin
						dead_q[rd_k_s1] <= 1'b1;
						free_q <= free_q | reg_onehot(rd_map_s1);
					end
				end
			end
		end
		if (state_q == ST_SEARCH && fit_res.done) begin
			found_q <= fit_res.found;
			pos_q <= fit_res.pos;
		end
		if (state_q == ST_COMMIT) begin
			ok_q <= alloc_ok;
			bad_def_q <= has_run && (range_bad || redef_q);
			full_q <= has_run && !range_bad && !redef_q && !found_q;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word = rsp_q;

	a_busy_commit_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COMMIT) |=> $stable(busy_q))
		else $error("busy bits changed outside commit");

	a_high_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (high_q >= $past(high_q)))
		else $error("high-water mark went down");

	a_high_range: assert property (@(posedge clk) disable iff (!arst_n)
		(high_q >= FIRST_X) && (high_q <= TOP_X))
		else $error("high-water mark out of register range");

	a_no_write_while_reading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_FIT) |-> !(map_we || lr_we))
		else $error("map write during read phase");

	a_no_room_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.status == STAT_NO_ROOM) |-> (rsp_word.dest_reg == FIRST_R))
		else $error("failed define returned a register");

endmodule

// File: sv/ffra_run_finder.sv
`timescale 1ns / 1ps

module ffra_run_finder #(
	parameter int SPAN = 80
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [SPAN-1:0]                busy,
	input  logic [ffra_pkg::RUN_W-1:0]     run_len,
	output ffra_pkg::ffra_fit_t            fit
);
	import ffra_pkg::*;

	localparam int NCH    = (SPAN + CHUNK - 1) / CHUNK;
	localparam int PAD_W  = NCH * CHUNK;
	localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CK_W   = $clog2(CHUNK);
	localparam int MAXRUN = (1 << RUN_W) - 1;

	logic [SPAN+MAXRUN-1:0] busy_pad;
	logic [PAD_W-1:0]       fit_d;
	logic [PAD_W-1:0]       fit_q;
	logic [CH_W-1:0]        chunk_q;
	logic                   active_q;
	logic [CHUNK-1:0]       cur;
	logic [CK_W-1:0]        lsb;
	logic                   any;
	logic                   last;

	// start positions whose whole run is free, past the end counts as busy
	always_comb begin
		logic ok;
		busy_pad = {{MAXRUN{1'b1}}, busy};
		fit_d = '0;
		for (int p = 0; p < SPAN; p++) begin
			ok = 1'b1;
			for (int j = 0; j < MAXRUN; j++) begin
				if (RUN_W'(j) < run_len && busy_pad[p+j]) begin
					ok = 1'b0;
				end
			end
			fit_d[p] = ok;
		end
	end

	always_comb begin
		cur = fit_q[chunk_q*CHUNK +: CHUNK];
		any = |cur;
		lsb = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			if (cur[i]) begin
				lsb = CK_W'(i);
			end
		end
		last = (chunk_q == CH_W'(NCH - 1));
		fit.done  = active_q && (any || last);
		fit.found = active_q && any;
		fit.pos   = (REG_W'(chunk_q) << CK_W) + REG_W'(lsb);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fit_q <= fit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			chunk_q <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			chunk_q <= '0;
		end else if (active_q) begin
			if (any || last) begin
				active_q <= 1'b0;
			end else begin
				chunk_q <= chunk_q + CH_W'(1);
			end
		end
	end

endmodule
